[rtl/core/shape_table_best_fit_defines.svh]
`ifndef SHAPE_TABLE_BEST_FIT_DEFINES_SVH
`define SHAPE_TABLE_BEST_FIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define STBF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shape table check failed");

// next-cycle implication, sampled on clk, off during reset
`define STBF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shape table check failed");

`endif

[rtl/core/stbf_pkg.sv]
package stbf_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int DIM_BITS_DEF    = 32;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_FIND   = 3'd1,
    OP_FLOOR  = 3'd2,
    OP_FIT    = 3'd3,
    OP_READ   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DUP      = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] height;
    logic [31:0] width;
    logic        kind;
    logic [5:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  index;
    logic [31:0] found_height;
    logic [31:0] found_width;
    logic        found_kind;
    logic [15:0] dup_count;
  } out_item_t;

endpackage

[rtl/core/stbf_cell.sv]
module stbf_cell #(
  parameter int DIM_BITS = stbf_pkg::DIM_BITS_DEF
) (
  input  logic                clk,
  input  logic                shift_en,
  input  logic [DIM_BITS-1:0] d_height,
  input  logic [DIM_BITS-1:0] d_width,
  input  logic                d_kind,
  input  logic [15:0]         d_count,
  output logic [DIM_BITS-1:0] q_height,
  output logic [DIM_BITS-1:0] q_width,
  output logic                q_kind,
  output logic [15:0]         q_count
);
  import stbf_pkg::*;

  logic [DIM_BITS-1:0] height_r;
  logic [DIM_BITS-1:0] width_r;
  logic                kind_r;
  logic [15:0]         count_r;

  // one table entry, takes its neighbor's entry on each shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      height_r <= d_height;
      width_r  <= d_width;
      kind_r   <= d_kind;
      count_r  <= d_count;
    end
  end

  assign q_height = height_r;
  assign q_width  = width_r;
  assign q_kind   = kind_r;
  assign q_count  = count_r;

endmodule

[rtl/core/shape_table_best_fit.sv]
// an accepted item passes through the scan and finish states; the result beat is held in the done state
// one item at a time: input stalls until the result beat is taken; each item makes one turn of the ring
// every operation rotates the whole cell ring once past the head compare logic
// reset clears the fill level and control state; entry cells are not cleared
module shape_table_best_fit #(
  parameter int TABLE_DEPTH = stbf_pkg::TABLE_DEPTH_DEF,
  parameter int DIM_BITS    = stbf_pkg::DIM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stbf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stbf_pkg::out_item_t out_data
);
  import stbf_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH);
  localparam int FW = CW + 1;
  localparam int XW = CW + 6;

  state_t state_r, state_nxt;

  op_t                 op_r;
  logic [DIM_BITS-1:0] h_r, w_r;
  logic                k_r;
  logic [5:0]          p_r;
  logic [CW-1:0]       cnt_r;
  logic [FW-1:0]       fill_r;
  logic                found_r, app_r, stop_r, e0big_r, got_r;
  logic [DIM_BITS-1:0] best_h_r, best_w_r;
  logic [5:0]          cap_idx_r;
  logic [DIM_BITS-1:0] cap_h_r, cap_w_r;
  logic                cap_k_r;
  logic [15:0]         cap_c_r;
  out_item_t           out_r;

  logic                shift_en;
  logic [DIM_BITS-1:0] cell_h [TABLE_DEPTH];
  logic [DIM_BITS-1:0] cell_w [TABLE_DEPTH];
  logic                cell_k [TABLE_DEPTH];
  logic [15:0]         cell_c [TABLE_DEPTH];

  logic [DIM_BITS-1:0] mod_h, mod_w;
  logic                mod_k;
  logic [15:0]         mod_c;

  // cell ring, the head entry comes back to the tail after the compare logic
  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    logic [DIM_BITS-1:0] dh, dw;
    logic                dk;
    logic [15:0]         dc;
    if (j == TABLE_DEPTH - 1) begin : g_tail
      assign dh = mod_h;
      assign dw = mod_w;
      assign dk = mod_k;
      assign dc = mod_c;
    end else begin : g_mid
      assign dh = cell_h[j+1];
      assign dw = cell_w[j+1];
      assign dk = cell_k[j+1];
      assign dc = cell_c[j+1];
    end
    stbf_cell #(.DIM_BITS(DIM_BITS)) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_height (dh),
      .d_width  (dw),
      .d_kind   (dk),
      .d_count  (dc),
      .q_height (cell_h[j]),
      .q_width  (cell_w[j]),
      .q_kind   (cell_k[j]),
      .q_count  (cell_c[j])
    );
  end

  // head compare
  logic [FW-1:0] i_ext;
  logic in_tab, full, match, last;
  logic ins_dup, ins_new;
  logic [DIM_BITS-1:0] e0h, e0w;

  assign e0h    = cell_h[0];
  assign e0w    = cell_w[0];
  assign i_ext  = FW'(cnt_r);
  assign in_tab = i_ext < fill_r;
  assign full   = fill_r == FW'(TABLE_DEPTH);
  assign match  = (e0h == h_r) && (e0w == w_r);
  assign last   = cnt_r == CW'(TABLE_DEPTH - 1);
  assign ins_dup = (op_r == OP_INSERT) && in_tab && !found_r && match;
  assign ins_new = (op_r == OP_INSERT) && (i_ext == fill_r) && !found_r && !full;

  // head entry as written back to the tail
  always_comb begin
    mod_h = e0h;
    mod_w = e0w;
    mod_k = cell_k[0];
    mod_c = cell_c[0];
    if (ins_dup) begin
      mod_c = (cell_c[0] == COUNT_MAX) ? cell_c[0] : cell_c[0] + 16'd1;
    end else if (ins_new) begin
      mod_h = h_r;
      mod_w = w_r;
      mod_k = k_r;
      mod_c = 16'd1;
    end
  end

  // per-operation selection at the head
  logic cap_en, found_nxt, app_nxt, stop_nxt, e0big_nxt, got_nxt;
  logic [DIM_BITS-1:0] best_h_nxt, best_w_nxt;

  always_comb begin
    cap_en     = 1'b0;
    found_nxt  = found_r;
    app_nxt    = app_r;
    stop_nxt   = stop_r;
    e0big_nxt  = e0big_r;
    got_nxt    = got_r;
    best_h_nxt = best_h_r;
    best_w_nxt = best_w_r;
    unique case (op_r)
      OP_INSERT: begin
        if (ins_dup) begin
          cap_en    = 1'b1;
          found_nxt = 1'b1;
        end else if (ins_new) begin
          cap_en  = 1'b1;
          app_nxt = 1'b1;
        end
      end
      OP_FIND: begin
        if (in_tab && !found_r && match) begin
          cap_en    = 1'b1;
          found_nxt = 1'b1;
        end
      end
      OP_FLOOR: begin
        if (cnt_r == '0) cap_en = 1'b1;
        if (in_tab && (e0h > best_h_r) && (e0h <= h_r)) begin
          cap_en     = 1'b1;
          best_h_nxt = e0h;
          got_nxt    = 1'b1;
        end
      end
      OP_FIT: begin
        if (cnt_r == '0) begin
          cap_en     = 1'b1;
          best_h_nxt = e0h;
          best_w_nxt = e0w;
          e0big_nxt  = e0h > h_r;
          stop_nxt   = e0h > h_r;
        end else if (in_tab && !stop_r) begin
          if (e0h > h_r) begin
            stop_nxt = 1'b1;
          end else if (e0h > best_h_r) begin
            cap_en     = 1'b1;
            best_h_nxt = e0h;
            best_w_nxt = e0w;
          end else if (e0h == best_h_r) begin
            if (((e0w > best_w_r) && (e0w <= w_r)) ||
                ((e0w < best_w_r) && (best_w_r > w_r))) begin
              cap_en     = 1'b1;
              best_w_nxt = e0w;
            end
          end
        end
      end
      OP_READ: begin
        if (in_tab && (XW'(cnt_r) == XW'(p_r))) begin
          cap_en    = 1'b1;
          found_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result for the finished scan
  out_item_t res;
  logic      has;
  logic [63:0] xh, xw;

  always_comb begin
    has        = 1'b0;
    res        = '0;
    res.status = ST_NOTFOUND;
    unique case (op_r)
      OP_INSERT: begin
        has        = found_r || app_r;
        res.status = found_r ? ST_DUP : (app_r ? ST_INSERTED : ST_FULL);
      end
      OP_FIND: begin
        has        = found_r;
        res.status = (fill_r == '0) ? ST_EMPTY : (found_r ? ST_HIT : ST_NOTFOUND);
      end
      OP_FLOOR: begin
        has        = fill_r != '0;
        res.status = (fill_r == '0) ? ST_EMPTY : (got_r ? ST_HIT : ST_NOTFOUND);
      end
      OP_FIT: begin
        has        = fill_r != '0;
        res.status = (fill_r == '0) ? ST_EMPTY : (e0big_r ? ST_NOTFOUND : ST_HIT);
      end
      OP_READ: begin
        has        = found_r;
        res.status = (fill_r == '0) ? ST_EMPTY : (found_r ? ST_HIT : ST_NOTFOUND);
      end
      OP_CLEAR: begin
        res.status = ST_HIT;
      end
      default: begin
      end
    endcase
    xh = 64'(cap_h_r);
    xw = 64'(cap_w_r);
    if (has) begin
      res.index        = cap_idx_r;
      res.found_height = xh[31:0];
      res.found_width  = xw[31:0];
      res.found_kind   = cap_k_r;
      res.dup_count    = cap_c_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_SCAN;
      S_SCAN:   if (last) state_nxt = S_FINISH;
      S_FINISH: state_nxt = S_DONE;
      S_DONE:   if (!out_stall) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = state_r != S_IDLE;
    out_valid = state_r == S_DONE;
    shift_en  = state_r == S_SCAN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FINISH) begin
        if (op_r == OP_CLEAR) fill_r <= '0;
        else if (app_r) fill_r <= fill_r + FW'(1);
      end
    end
  end

  // operation registers and scan bookkeeping
  logic [XW-1:0] cnt_x;
  assign cnt_x = XW'(cnt_r);

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      op_r     <= op_t'(in_data.op);
      h_r      <= DIM_BITS'(in_data.height);
      w_r      <= DIM_BITS'(in_data.width);
      k_r      <= in_data.kind;
      p_r      <= in_data.position;
      cnt_r    <= '0;
      found_r  <= 1'b0;
      app_r    <= 1'b0;
      stop_r   <= 1'b0;
      e0big_r  <= 1'b0;
      got_r    <= 1'b0;
      best_h_r <= '0;
      best_w_r <= '0;
    end else if (state_r == S_SCAN) begin
      cnt_r    <= cnt_r + CW'(1);
      found_r  <= found_nxt;
      app_r    <= app_nxt;
      stop_r   <= stop_nxt;
      e0big_r  <= e0big_nxt;
      got_r    <= got_nxt;
      best_h_r <= best_h_nxt;
      best_w_r <= best_w_nxt;
      if (cap_en) begin
        cap_idx_r <= cnt_x[5:0];
        cap_h_r   <= mod_h;
        cap_w_r   <= mod_w;
        cap_k_r   <= mod_k;
        cap_c_r   <= mod_c;
      end
    end
    if (state_r == S_FINISH) out_r <= res;
  end

  assign out_data = out_r;

endmodule

[rtl/core/stbf_checker.sv]
`include "shape_table_best_fit_defines.svh"

module stbf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input stbf_pkg::out_item_t out_data
);
  import stbf_pkg::*;

  // a result beat holds while stalled
  `STBF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `STBF_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  // one item at a time: an accepted beat closes the input side
  `STBF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall && !out_valid)
  // no input taken while a result waits
  `STBF_ASSERT_NOW(a_no_overlap, out_valid, in_stall)

endmodule

bind shape_table_best_fit stbf_checker u_stbf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
